FILE: src/gri_pkg.sv
// ----------------------------------------------------------------------------
// Gyro rate integrator package
// Shared widths, constants, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
package gri_pkg;

   localparam int GAIN_BITS     = 28;
   localparam int SUM_BITS      = 48;
   localparam int YAW_BITS      = 22;
   localparam int RES_BITS      = 64;
   localparam int QUANT_SHIFT   = 32;
   localparam int QUANT_BITS    = 16;
   localparam int DIV_STEP_BITS = $clog2(SUM_BITS + 1);

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 28'd10485760;
   localparam logic [YAW_BITS-1:0]  FULL_TURN  = 22'd3600000;

   localparam logic OP_INTEGRATE = 1'b0;
   localparam logic OP_AVERAGE   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_QUANT,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DONE
   } state_type;

endpackage

FILE: src/gri_divider.sv
// ----------------------------------------------------------------------------
// Gyro rate integrator divider
// Restoring unsigned divider, one quotient bit per cycle over the full sum
// width. A start pulse loads the operands; done pulses with the quotient.
// ----------------------------------------------------------------------------
module gri_divider #(
   parameter int COUNT_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gri_pkg::SUM_BITS-1:0]  dividend,
   input  logic [COUNT_BITS:0]           divisor,
   output logic                          done,
   output logic [gri_pkg::SUM_BITS-1:0]  quotient
);
   import gri_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [COUNT_BITS:0]      rem_ff, rem_in;
   logic [SUM_BITS-1:0]      quo_ff, quo_in;
   logic [COUNT_BITS:0]      den_ff, den_in;
   logic [COUNT_BITS+1:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[SUM_BITS-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_STEP_BITS'(SUM_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         // Shift in the next dividend bit and subtract when the divisor fits.
         if (trial >= {1'b0, den_ff}) begin
            rem_in = (COUNT_BITS+1)'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = (COUNT_BITS+1)'(trial);
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/gyro_rate_integrator_unit.sv
// ----------------------------------------------------------------------------
// Gyro rate integrator unit
// Trapezoidal yaw integration of the Z rate with per-axis rate averaging.
// ----------------------------------------------------------------------------
// An integrate word (op 0) runs one multiply, one saturating residual add and
// one quantum extraction step, then the result stage, before the next word
// can be accepted. An average word (op 1) with samples present runs the
// shared restoring divider once per axis over the full sum width, with a
// handoff through the start state around each run. An average word with no
// samples goes straight to the result stage. A finished result sits in the
// output register while the next word is accepted.
module gyro_rate_integrator_unit #(
   parameter int RATE_BITS  = 24,
   parameter int COUNT_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic signed [RATE_BITS-1:0]   req_rate_x,
   input  logic signed [RATE_BITS-1:0]   req_rate_y,
   input  logic signed [RATE_BITS-1:0]   req_rate_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gri_pkg::YAW_BITS-1:0]  rsp_yaw_angle,
   output logic                          rsp_avg_valid,
   output logic signed [RATE_BITS-1:0]   rsp_avg_x,
   output logic signed [RATE_BITS-1:0]   rsp_avg_y,
   output logic signed [RATE_BITS-1:0]   rsp_avg_z,
   input  logic                          csr_wr_en,
   input  logic [gri_pkg::GAIN_BITS-1:0] csr_wr_data
);
   import gri_pkg::*;

   localparam int PAIR_W = RATE_BITS + 1;
   localparam int PROD_W = PAIR_W + GAIN_BITS + 1;
   localparam logic [SUM_BITS-1:0] RATE_HALF = SUM_BITS'(1) << (RATE_BITS - 1);

   state_type                  state_ff, state_in;
   logic [GAIN_BITS-1:0]       gain_ff, gain_in;
   logic signed [RATE_BITS-1:0] rate_ff [3];
   logic signed [RATE_BITS-1:0] rate_in [3];
   logic signed [RATE_BITS-1:0] prev_ff [3];
   logic signed [RATE_BITS-1:0] prev_in [3];
   logic signed [SUM_BITS-1:0]  sum_ff [3];
   logic signed [SUM_BITS-1:0]  sum_in [3];
   logic signed [RATE_BITS-1:0] avg_ff [3];
   logic signed [RATE_BITS-1:0] avg_in [3];
   logic                       avg_valid_ff, avg_valid_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [RES_BITS-1:0] residual_ff, residual_in;
   logic [YAW_BITS-1:0]        yaw_ff, yaw_in;
   logic [1:0]                 axis_ff, axis_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [YAW_BITS-1:0]        rsp_yaw_ff, rsp_yaw_in;
   logic                       rsp_avg_valid_ff, rsp_avg_valid_in;
   logic signed [RATE_BITS-1:0] rsp_avg_ff [3];
   logic signed [RATE_BITS-1:0] rsp_avg_in [3];

   logic                       div_start;
   logic                       div_done;
   logic [SUM_BITS-1:0]        div_dividend;
   logic [SUM_BITS-1:0]        div_quotient;

   logic signed [PAIR_W-1:0]   pair [3];
   logic signed [SUM_BITS:0]   sum_ext [3];
   logic signed [PROD_W-1:0]   pz_ext;
   logic signed [PROD_W-1:0]   g_ext;
   logic signed [RES_BITS:0]   res_ext;
   logic signed [31:0]         q_hi;
   logic signed [31:0]         q_trunc;
   logic signed [QUANT_BITS-1:0] q16;
   logic signed [YAW_BITS+1:0] yaw_next;
   logic                       sum_neg;

   gri_divider #(
      .COUNT_BITS(COUNT_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor ({count_ff, 1'b0}),
      .done    (div_done),
      .quotient(div_quotient)
   );

   assign sum_neg      = sum_ff[axis_ff][SUM_BITS-1];
   assign div_dividend = sum_neg ? SUM_BITS'(-sum_ff[axis_ff]) : SUM_BITS'(sum_ff[axis_ff]);

   always_comb begin
      state_in         = state_ff;
      gain_in          = csr_wr_en ? csr_wr_data : gain_ff;
      avg_valid_in     = avg_valid_ff;
      count_in         = count_ff;
      prod_in          = prod_ff;
      residual_in      = residual_ff;
      yaw_in           = yaw_ff;
      axis_in          = axis_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_yaw_in       = rsp_yaw_ff;
      rsp_avg_valid_in = rsp_avg_valid_ff;
      div_start        = 1'b0;
      for (int a = 0; a < 3; a++) begin
         rate_in[a]    = rate_ff[a];
         prev_in[a]    = prev_ff[a];
         sum_in[a]     = sum_ff[a];
         avg_in[a]     = avg_ff[a];
         rsp_avg_in[a] = rsp_avg_ff[a];
         pair[a]       = {rate_ff[a][RATE_BITS-1], rate_ff[a]} +
                         {prev_ff[a][RATE_BITS-1], prev_ff[a]};
         sum_ext[a]    = {sum_ff[a][SUM_BITS-1], sum_ff[a]} +
                         {{(SUM_BITS+1-PAIR_W){pair[a][PAIR_W-1]}}, pair[a]};
      end
      pz_ext   = {{(PROD_W-PAIR_W){pair[2][PAIR_W-1]}}, pair[2]};
      g_ext    = {{(PROD_W-GAIN_BITS){1'b0}}, gain_ff};
      res_ext  = {residual_ff[RES_BITS-1], residual_ff} +
                 {{(RES_BITS+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      q_hi     = residual_ff[RES_BITS-1:QUANT_SHIFT];
      // Arithmetic shift floors; a negative residual with a fraction rounds up.
      q_trunc  = q_hi + ((q_hi < 0 && residual_ff[QUANT_SHIFT-1:0] != '0) ? 32'sd1 : 32'sd0);
      if (q_trunc > 32'sd32767) begin
         q16 = 16'sh7fff;
      end else if (q_trunc < -32'sd32768) begin
         q16 = 16'sh8000;
      end else begin
         q16 = q_trunc[QUANT_BITS-1:0];
      end
      yaw_next = $signed({2'b00, yaw_ff}) - {{(YAW_BITS+2-QUANT_BITS){q16[QUANT_BITS-1]}}, q16};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rate_in[0]   = req_rate_x;
               rate_in[1]   = req_rate_y;
               rate_in[2]   = req_rate_z;
               avg_valid_in = 1'b0;
               for (int a = 0; a < 3; a++) begin
                  avg_in[a] = '0;
               end
               if (req_op == OP_AVERAGE) begin
                  if (count_ff != '0) begin
                     avg_valid_in = 1'b1;
                     axis_in      = 2'd0;
                     state_in     = ST_DIV_START;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            for (int a = 0; a < 3; a++) begin
               if (sum_ext[a][SUM_BITS] != sum_ext[a][SUM_BITS-1]) begin
                  sum_in[a] = sum_ext[a][SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
               end else begin
                  sum_in[a] = sum_ext[a][SUM_BITS-1:0];
               end
               prev_in[a] = rate_ff[a];
            end
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            prod_in  = pz_ext * g_ext;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (res_ext[RES_BITS] != res_ext[RES_BITS-1]) begin
               residual_in = res_ext[RES_BITS] ? {1'b1, {(RES_BITS-1){1'b0}}}
                                               : {1'b0, {(RES_BITS-1){1'b1}}};
            end else begin
               residual_in = res_ext[RES_BITS-1:0];
            end
            state_in = ST_QUANT;
         end
         ST_QUANT: begin
            residual_in = {residual_ff[RES_BITS-1:QUANT_SHIFT] -
                           {{(RES_BITS-QUANT_SHIFT-QUANT_BITS){q16[QUANT_BITS-1]}}, q16},
                           residual_ff[QUANT_SHIFT-1:0]};
            if (yaw_next < 0) begin
               yaw_in = YAW_BITS'(yaw_next + $signed({2'b00, FULL_TURN}));
            end else if (yaw_next >= $signed({2'b00, FULL_TURN})) begin
               yaw_in = YAW_BITS'(yaw_next - $signed({2'b00, FULL_TURN}));
            end else begin
               yaw_in = yaw_next[YAW_BITS-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               if (!sum_neg) begin
                  avg_in[axis_ff] = (div_quotient >= RATE_HALF) ?
                                    {1'b0, {(RATE_BITS-1){1'b1}}} :
                                    div_quotient[RATE_BITS-1:0];
               end else begin
                  avg_in[axis_ff] = (div_quotient > RATE_HALF) ?
                                    {1'b1, {(RATE_BITS-1){1'b0}}} :
                                    -div_quotient[RATE_BITS-1:0];
               end
               if (axis_ff == 2'd2) begin
                  for (int a = 0; a < 3; a++) begin
                     sum_in[a] = '0;
                  end
                  count_in = '0;
                  state_in = ST_DONE;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_yaw_in       = yaw_ff;
               rsp_avg_valid_in = avg_valid_ff;
               for (int a = 0; a < 3; a++) begin
                  rsp_avg_in[a] = avg_ff[a];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         count_ff     <= '0;
         residual_ff  <= '0;
         yaw_ff       <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            prev_ff[a] <= '0;
            sum_ff[a]  <= '0;
         end
      end else begin
         gain_ff      <= gain_in;
         count_ff     <= count_in;
         residual_ff  <= residual_in;
         yaw_ff       <= yaw_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int a = 0; a < 3; a++) begin
            prev_ff[a] <= prev_in[a];
            sum_ff[a]  <= sum_in[a];
         end
      end
      avg_valid_ff     <= avg_valid_in;
      prod_ff          <= prod_in;
      rsp_yaw_ff       <= rsp_yaw_in;
      rsp_avg_valid_ff <= rsp_avg_valid_in;
      for (int a = 0; a < 3; a++) begin
         rate_ff[a]    <= rate_in[a];
         avg_ff[a]     <= avg_in[a];
         rsp_avg_ff[a] <= rsp_avg_in[a];
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_yaw_angle = rsp_yaw_ff;
   assign rsp_avg_valid = rsp_avg_valid_ff;
   assign rsp_avg_x     = rsp_avg_ff[0];
   assign rsp_avg_y     = rsp_avg_ff[1];
   assign rsp_avg_z     = rsp_avg_ff[2];

   // The yaw angle delivered with a word is always wrapped into one turn.
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_yaw_angle < FULL_TURN)
      else $error("yaw angle outside one full turn");

   // Without a valid average, all three averages read as zero.
   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_avg_valid) |->
      (rsp_avg_x == '0 && rsp_avg_y == '0 && rsp_avg_z == '0))
      else $error("nonzero average without samples");

   // The divider only finishes while the sequencer waits for it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_RUN)
      else $error("divider finished outside a divide step");

   // A new divide only starts with samples present.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      div_start |-> count_ff != '0)
      else $error("divide started with an empty sample count");

endmodule

FILE: tb/gri_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro rate integrator checker
// Watches the request, result and register ports, predicts every result word
// from its own copy of the integrator state and compares field by field.
// ----------------------------------------------------------------------------
module gri_checker #(
   parameter int RATE_BITS  = 24,
   parameter int COUNT_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_op,
   input  logic signed [RATE_BITS-1:0]   req_rate_x,
   input  logic signed [RATE_BITS-1:0]   req_rate_y,
   input  logic signed [RATE_BITS-1:0]   req_rate_z,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [gri_pkg::YAW_BITS-1:0]  rsp_yaw_angle,
   input  logic                          rsp_avg_valid,
   input  logic signed [RATE_BITS-1:0]   rsp_avg_x,
   input  logic signed [RATE_BITS-1:0]   rsp_avg_y,
   input  logic signed [RATE_BITS-1:0]   rsp_avg_z,
   input  logic                          csr_wr_en,
   input  logic [gri_pkg::GAIN_BITS-1:0] csr_wr_data,
   output int                            mismatches,
   output int                            outstanding
);
   import gri_pkg::*;

   typedef struct packed {
      logic [YAW_BITS-1:0]         yaw;
      logic                        avg_valid;
      logic signed [RATE_BITS-1:0] avg_x;
      logic signed [RATE_BITS-1:0] avg_y;
      logic signed [RATE_BITS-1:0] avg_z;
   } readout_type;

   localparam longint SUM_MAX   = (longint'(1) << (SUM_BITS - 1)) - 1;
   localparam longint SUM_MIN   = -SUM_MAX - 1;
   localparam longint RATE_MAX  = (longint'(1) << (RATE_BITS - 1)) - 1;
   localparam longint RATE_MIN  = -RATE_MAX - 1;
   localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;
   localparam longint QUANTUM   = longint'(1) << QUANT_SHIFT;
   localparam longint TURN      = longint'(FULL_TURN);
   localparam longint RES_MAX   = 64'sh7fff_ffff_ffff_ffff;
   localparam longint RES_MIN   = -RES_MAX - 1;

   // Shadow of the integrator state.
   longint               last_rate [3];
   longint               rate_acc [3];
   longint               residual;
   longint               yaw;
   longint               samples;
   logic [GAIN_BITS-1:0] gain;

   readout_type readout_q [$];

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic readout_type compute_readout(input logic op,
                                                   input logic signed [RATE_BITS-1:0] rx,
                                                   input logic signed [RATE_BITS-1:0] ry,
                                                   input logic signed [RATE_BITS-1:0] rz);
      longint      rate [3];
      longint      avg [3];
      longint      pair, inc, sum, q, y, div;
      readout_type res;
      int          a;
      rate[0] = rx;
      rate[1] = ry;
      rate[2] = rz;
      avg     = '{0, 0, 0};
      res     = '0;
      if (op == OP_INTEGRATE) begin
         for (a = 0; a < 3; a++) begin
            pair = rate[a] + last_rate[a];
            if (a == 2) begin
               // The residual add saturates instead of wrapping.
               inc = pair * longint'({36'd0, gain});
               sum = residual + inc;
               if (residual[63] == inc[63] && sum[63] != residual[63]) begin
                  sum = residual[63] ? RES_MIN : RES_MAX;
               end
               residual = sum;
               q = clamp(residual / QUANTUM, -32768, 32767);
               residual = residual - q * QUANTUM;
               y = yaw - q;
               if (y < 0) begin
                  y = y + TURN;
               end else if (y >= TURN) begin
                  y = y - TURN;
               end
               yaw = y;
            end
            rate_acc[a]  = clamp(rate_acc[a] + pair, SUM_MIN, SUM_MAX);
            last_rate[a] = rate[a];
         end
         if (samples < COUNT_MAX) begin
            samples = samples + 1;
         end
      end else if (samples > 0) begin
         div = 2 * samples;
         for (a = 0; a < 3; a++) begin
            avg[a]      = clamp(rate_acc[a] / div, RATE_MIN, RATE_MAX);
            rate_acc[a] = 0;
         end
         samples       = 0;
         res.avg_valid = 1'b1;
      end
      res.yaw   = yaw[YAW_BITS-1:0];
      res.avg_x = avg[0][RATE_BITS-1:0];
      res.avg_y = avg[1][RATE_BITS-1:0];
      res.avg_z = avg[2][RATE_BITS-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      readout_type seen, want;
      int          a;
      if (reset) begin
         for (a = 0; a < 3; a++) begin
            last_rate[a] = 0;
            rate_acc[a]  = 0;
         end
         residual = 0;
         yaw      = 0;
         samples  = 0;
         gain     = GAIN_RESET;
         readout_q.delete();
      end else begin
         if (csr_wr_en) begin
            gain = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            readout_q.push_back(compute_readout(req_op, req_rate_x, req_rate_y,
                                                req_rate_z));
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_yaw_angle, rsp_avg_valid, rsp_avg_x, rsp_avg_y, rsp_avg_z};
            if (readout_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("%0t: result word with nothing expected: yaw=%0d valid=%0b",
                           $realtime, seen.yaw, seen.avg_valid);
               end
               mismatches = mismatches + 1;
            end else begin
               want = readout_q.pop_front();
               if (want.yaw !== seen.yaw || want.avg_valid !== seen.avg_valid ||
                   want.avg_x !== seen.avg_x || want.avg_y !== seen.avg_y ||
                   want.avg_z !== seen.avg_z) begin
                  if (mismatches < 10) begin
                     $display("%0t: expected yaw=%0d valid=%0b avg=%0d/%0d/%0d",
                              $realtime, want.yaw, want.avg_valid, want.avg_x,
                              want.avg_y, want.avg_z);
                     $display("%0t:   actual yaw=%0d valid=%0b avg=%0d/%0d/%0d",
                              $realtime, seen.yaw, seen.avg_valid, seen.avg_x,
                              seen.avg_y, seen.avg_z);
                  end
                  mismatches = mismatches + 1;
               end
            end
         end
      end
      outstanding <= readout_q.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gyro rate integrator testbench
// Drives integrate and average words with random idle gaps on both sides,
// steps the integration gain through its extremes between phases, and ends
// with a long run at full gain and near full rate that keeps the quantum
// move clamped.
// ----------------------------------------------------------------------------
module tb;
   import gri_pkg::*;

   localparam int RATE_BITS  = 24;
   localparam int COUNT_BITS = 20;

   localparam logic [RATE_BITS-1:0] RATE_HI  = {1'b0, {(RATE_BITS-1){1'b1}}};
   localparam logic [RATE_BITS-1:0] RATE_LO  = {1'b1, {(RATE_BITS-1){1'b0}}};
   localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;
   localparam logic [GAIN_BITS-1:0] GAIN_OFF = '0;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_op = OP_INTEGRATE;
   logic signed [RATE_BITS-1:0] req_rate_x = '0;
   logic signed [RATE_BITS-1:0] req_rate_y = '0;
   logic signed [RATE_BITS-1:0] req_rate_z = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [YAW_BITS-1:0]         rsp_yaw_angle;
   logic                        rsp_avg_valid;
   logic signed [RATE_BITS-1:0] rsp_avg_x;
   logic signed [RATE_BITS-1:0] rsp_avg_y;
   logic signed [RATE_BITS-1:0] rsp_avg_z;
   logic                        csr_wr_en = 1'b0;
   logic [GAIN_BITS-1:0]        csr_wr_data = '0;

   int mismatches;
   int outstanding;
   int words_offered = 0;
   bit sender_calm   = 1'b0;

   always #4 clock = ~clock;

   gyro_rate_integrator_unit #(
      .RATE_BITS (RATE_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_rate_x   (req_rate_x),
      .req_rate_y   (req_rate_y),
      .req_rate_z   (req_rate_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_avg_valid(rsp_avg_valid),
      .rsp_avg_x    (rsp_avg_x),
      .rsp_avg_y    (rsp_avg_y),
      .rsp_avg_z    (rsp_avg_z),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   gri_checker #(
      .RATE_BITS (RATE_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_rate_x   (req_rate_x),
      .req_rate_y   (req_rate_y),
      .req_rate_z   (req_rate_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_yaw_angle(rsp_yaw_angle),
      .rsp_avg_valid(rsp_avg_valid),
      .rsp_avg_x    (rsp_avg_x),
      .rsp_avg_y    (rsp_avg_y),
      .rsp_avg_z    (rsp_avg_z),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .mismatches   (mismatches),
      .outstanding  (outstanding)
   );

   // Valid stays high from one word to the next when there is no gap, so it
   // is lowered only at the start of a gap.
   task automatic offer_word(input logic op, input logic [RATE_BITS-1:0] x,
                             input logic [RATE_BITS-1:0] y,
                             input logic [RATE_BITS-1:0] z);
      int gap;
      if (words_offered % 40 == 0) begin
         sender_calm = ($urandom_range(0, 3) == 0);
      end
      words_offered++;
      gap = sender_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_op     <= op;
      req_rate_x <= x;
      req_rate_y <= y;
      req_rate_z <= z;
      do @(posedge clock); while (req_stall);
   endtask

   // Waits for every pending result, then writes the gain while idle.
   task automatic load_gain(input logic [GAIN_BITS-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [RATE_BITS-1:0] pick_rate();
      int v;
      case ($urandom_range(0, 9))
         0:       v = int'(RATE_HI);
         1:       v = {{(32-RATE_BITS){1'b1}}, RATE_LO};
         2, 3, 4: v = int'($urandom_range(0, 2000)) - 1000;
         default: v = $urandom();
      endcase
      return v[RATE_BITS-1:0];
   endfunction

   task automatic random_phase(input int words);
      logic op;
      for (int n = 0; n < words; n++) begin
         op = ($urandom_range(0, 11) == 0) ? OP_AVERAGE : OP_INTEGRATE;
         offer_word(op, pick_rate(), pick_rate(), pick_rate());
      end
   endtask

   // Result side: random stall before each word, calm stretches, and one
   // long hold-off while the sender keeps offering words.
   initial begin : result_side
      int hold;
      int taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         hold = calm ? 0 : $urandom_range(0, 8);
         if (taken == 100) begin
            hold = 500;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : stimulus
      logic [RATE_BITS-1:0] top_z;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset gain.
      offer_word(OP_AVERAGE, RATE_HI, RATE_LO, RATE_HI);     // nothing to average
      offer_word(OP_INTEGRATE, RATE_HI, RATE_HI, RATE_HI);   // wrap low; the next word clamps the quantum
      offer_word(OP_INTEGRATE, RATE_HI, RATE_HI, RATE_HI);
      offer_word(OP_AVERAGE, '0, '0, '0);
      offer_word(OP_INTEGRATE, RATE_LO, RATE_LO, RATE_LO);   // wrap past a full turn
      offer_word(OP_INTEGRATE, RATE_LO, RATE_LO, RATE_LO);
      offer_word(OP_INTEGRATE, RATE_LO, RATE_LO, RATE_LO);
      offer_word(OP_AVERAGE, RATE_HI, RATE_HI, RATE_HI);
      offer_word(OP_AVERAGE, RATE_LO, RATE_LO, RATE_LO);
      offer_word(OP_INTEGRATE, '0, '0, '0);
      offer_word(OP_INTEGRATE, RATE_HI, RATE_LO, 24'sd1);
      offer_word(OP_INTEGRATE, RATE_LO, RATE_HI, -24'sd1);
      offer_word(OP_INTEGRATE, 24'sd3, -24'sd5, -24'sd1);
      offer_word(OP_AVERAGE, '0, '0, '0);
      offer_word(OP_INTEGRATE, 24'h555555, 24'haaaaaa, 24'h555555);
      offer_word(OP_INTEGRATE, 24'haaaaaa, 24'h555555, 24'haaaaaa);
      offer_word(OP_INTEGRATE, 24'haaaaaa, 24'h555555, 24'haaaaaa);
      offer_word(OP_AVERAGE, '0, '0, '0);

      load_gain(GAIN_MAX);
      random_phase(150);
      load_gain(28'd1);
      random_phase(150);
      load_gain(GAIN_OFF);       // yaw only drains what the residual holds
      random_phase(100);
      load_gain(GAIN_BITS'($urandom_range(1, 28'hfffffff)));
      random_phase(150);
      load_gain(GAIN_RESET);
      random_phase(150);

      // Full gain and near full positive Z rate build a large residual and
      // keep the quantum move clamped on every sample.
      load_gain(GAIN_MAX);
      for (int n = 0; n < 760; n++) begin
         top_z = RATE_HI - RATE_BITS'($urandom_range(0, 255));
         offer_word(($urandom_range(0, 39) == 0) ? OP_AVERAGE : OP_INTEGRATE,
                    pick_rate(), pick_rate(), top_z);
      end
      offer_word(OP_AVERAGE, '0, '0, '0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
